FILE: sv/fsdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsdc_pkg
// Shared types and constants of the float32 to scaled decimal converter.
// ----------------------------------------------------------------------------
package fsdc_pkg;

   localparam int NW = 176;
   typedef logic [NW-1:0] big_type;

   localparam logic [23:0] TEN6    = 24'd1000000;
   localparam logic [23:0] TEN7    = 24'd10000000;
   localparam logic [31:0] MAGIC10 = 32'hCCCCCCCD;

   localparam logic [6:0] MAX_LOG2_RESET  = 7'd96;
   localparam logic [6:0] MIN_EXP10_RESET = 7'h64;

   localparam logic REG_MAX_LOG2  = 1'b0;
   localparam logic REG_MIN_EXP10 = 1'b1;

   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_NORM   = 4'd2;
   localparam logic [3:0] OP_INIT   = 4'd3;
   localparam logic [3:0] OP_SCALE  = 4'd4;
   localparam logic [3:0] OP_DIVSET = 4'd5;
   localparam logic [3:0] OP_DIV    = 4'd6;
   localparam logic [3:0] OP_ROUND  = 4'd7;
   localparam logic [3:0] OP_STRIP  = 4'd8;
   localparam logic [3:0] OP_SCL    = 4'd9;
   localparam logic [3:0] OP_WIDEN  = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic norm_done;
      logic err;
      logic scale_done;
      logic div_last;
      logic strip_done;
      logic widen_done;
   } status_type;

endpackage
`default_nettype wire

FILE: sv/fsdc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsdc_dp
// Datapath: exact rational scaling, restoring divide, rounding, digit strip and widening.
// ----------------------------------------------------------------------------
module fsdc_dp import fsdc_pkg::*; (
   input  wire logic        clock,
   input  wire cmd_type     cmd,
   input  wire logic [31:0] float_bits,
   input  wire logic [6:0]  max_log2,
   input  wire logic [6:0]  min_exp10,
   output status_type       st,
   output logic             error,
   output logic [31:0]      coeff_low,
   output logic [31:0]      coeff_mid,
   output logic [31:0]      coeff_high,
   output logic [5:0]       scale,
   output logic             negative
);

   logic               sign_ff, err_ff, zero_ff;
   logic [23:0]        m_ff, mn_ff, q_ff;
   logic signed [8:0]  e_ff, pe_ff;
   logic signed [7:0]  k_ff, scl_ff;
   logic [2:0]         z_ff;
   logic [4:0]         cnt_ff;
   big_type            n_ff, d_ff, d6_ff, dsh_ff;
   logic [95:0]        coef_ff;

   logic [7:0]         ef;
   logic [23:0]        ld_m;
   logic signed [8:0]  ld_e, lim, neg_e;
   logic signed [7:0]  mine, scl_calc;
   logic [7:0]         shamt;
   logic               too_large, too_small, n_lt, n_ge, rem_ge, up, wrap, rz;
   big_type            n10, d10, d6x10, two_rem, init_n, init_d, init_d6;
   logic [24:0]        q_up;
   logic [55:0]        prod;
   logic [20:0]        quot;
   logic [23:0]        q10;
   logic [99:0]        c10;
   logic               pass;

   assign ef    = float_bits[30:23];
   assign ld_m  = (ef == 8'd0) ? {1'b0, float_bits[22:0]} : {1'b1, float_bits[22:0]};
   assign ld_e  = (ef == 8'd0) ? -9'sd149 : $signed({1'b0, ef}) - 9'sd150;
   assign lim   = $signed({2'b00, max_log2});
   assign too_large = (pe_ff > lim) || ((pe_ff == lim) && (mn_ff[22:0] != 23'd0));
   assign mine  = $signed({min_exp10[6], min_exp10});
   assign too_small = k_ff < mine;

   assign neg_e = -e_ff;
   assign shamt = e_ff[8] ? neg_e[7:0] : e_ff[7:0];
   assign init_n  = e_ff[8] ? big_type'(m_ff) : (big_type'(m_ff) << shamt);
   assign init_d  = e_ff[8] ? (big_type'(1) << shamt) : big_type'(1);
   assign init_d6 = e_ff[8] ? (big_type'(TEN6) << shamt) : big_type'(TEN6);

   assign n10   = (n_ff << 3) + (n_ff << 1);
   assign d10   = (d_ff << 3) + (d_ff << 1);
   assign d6x10 = (d6_ff << 3) + (d6_ff << 1);
   assign n_lt  = n_ff < d6_ff;
   assign n_ge  = n_ff >= d6x10;
   assign rem_ge = n_ff >= dsh_ff;

   assign two_rem = n_ff << 1;
   assign up   = (two_rem > d_ff) || ((two_rem == d_ff) && q_ff[0]);
   assign q_up = {1'b0, q_ff} + {24'd0, up};
   assign wrap = q_up == {1'b0, TEN7};

   assign prod = {32'd0, q_ff} * {24'd0, MAGIC10};
   assign quot = prod[55:35];
   assign q10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rz   = q10 == q_ff;

   assign scl_calc = 8'sd6 - k_ff - $signed({5'd0, z_ff});
   assign c10 = {1'b0, coef_ff, 3'b000} + {3'b000, coef_ff, 1'b0};

   always_comb begin
      st.special    = err_ff | zero_ff;
      st.norm_done  = mn_ff[23];
      st.err        = err_ff;
      st.scale_done = !n_lt && !n_ge;
      st.div_last   = cnt_ff == 5'd0;
      st.strip_done = (z_ff == 3'd6) || !rz;
      st.widen_done = !scl_ff[7];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            sign_ff <= float_bits[31];
            err_ff  <= ef == 8'hFF;
            zero_ff <= (ef != 8'hFF) && (ld_m == 24'd0);
            m_ff    <= ld_m;
            mn_ff   <= ld_m;
            e_ff    <= ld_e;
            pe_ff   <= ld_e + 9'sd23;
         end
         OP_NORM: begin
            if (!mn_ff[23]) begin
               mn_ff <= mn_ff << 1;
               pe_ff <= pe_ff - 9'sd1;
            end
         end
         OP_INIT: begin
            n_ff  <= init_n;
            d_ff  <= init_d;
            d6_ff <= init_d6;
            k_ff  <= 8'sd6;
            if (too_large) begin
               err_ff <= 1'b1;
            end
         end
         OP_SCALE: begin
            if (n_lt) begin
               n_ff <= n10;
               k_ff <= k_ff - 8'sd1;
            end else if (n_ge) begin
               d_ff  <= d10;
               d6_ff <= d6x10;
               k_ff  <= k_ff + 8'sd1;
            end
         end
         OP_DIVSET: begin
            dsh_ff <= d_ff << 23;
            q_ff   <= 24'd0;
            cnt_ff <= 5'd23;
            if (too_small) begin
               err_ff <= 1'b1;
            end
         end
         OP_DIV: begin
            if (rem_ge) begin
               n_ff         <= n_ff - dsh_ff;
               q_ff[cnt_ff] <= 1'b1;
            end
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
         end
         OP_ROUND: begin
            if (wrap) begin
               q_ff <= TEN6;
               k_ff <= k_ff + 8'sd1;
            end else begin
               q_ff <= q_up[23:0];
            end
            z_ff <= 3'd0;
         end
         OP_STRIP: begin
            if (!st.strip_done) begin
               q_ff <= {3'd0, quot};
               z_ff <= z_ff + 3'd1;
            end
         end
         OP_SCL: begin
            scl_ff  <= scl_calc;
            coef_ff <= {72'd0, q_ff};
         end
         OP_WIDEN: begin
            if (scl_ff[7]) begin
               if (c10[99:96] != 4'd0) begin
                  err_ff <= 1'b1;
               end else begin
                  coef_ff <= c10[95:0];
               end
               scl_ff <= scl_ff + 8'sd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign pass       = !err_ff && !zero_ff;
   assign error      = err_ff;
   assign coeff_low  = pass ? coef_ff[31:0]  : 32'd0;
   assign coeff_mid  = pass ? coef_ff[63:32] : 32'd0;
   assign coeff_high = pass ? coef_ff[95:64] : 32'd0;
   assign scale      = pass ? scl_ff[5:0] : 6'd0;
   assign negative   = pass & sign_ff;

endmodule
`default_nettype wire

FILE: sv/fsdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsdc_ctrl
// Sequencer: steps the datapath through one conversion and hands off the item.
// ----------------------------------------------------------------------------
module fsdc_ctrl import fsdc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       out_free,
   input  wire status_type st,
   output logic            req_ready,
   output cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NORM   = 4'd1;
   localparam logic [3:0] S_INIT   = 4'd2;
   localparam logic [3:0] S_SCALE  = 4'd3;
   localparam logic [3:0] S_DIVSET = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_ROUND  = 4'd6;
   localparam logic [3:0] S_STRIP  = 4'd7;
   localparam logic [3:0] S_SCL    = 4'd8;
   localparam logic [3:0] S_WIDEN  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.emit  = 1'b0;
      req_ready = state_ff == S_IDLE;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (st.special) begin
               state_in = S_DONE;
            end else if (st.norm_done) begin
               state_in = S_INIT;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (st.err) begin
               state_in = S_DONE;
            end else if (st.scale_done) begin
               state_in = S_DIVSET;
            end else begin
               cmd.op = OP_SCALE;
            end
         end
         S_DIVSET: begin
            cmd.op   = OP_DIVSET;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (st.err) begin
               state_in = S_DONE;
            end else begin
               cmd.op = OP_DIV;
               if (st.div_last) begin
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_STRIP;
         end
         S_STRIP: begin
            if (st.strip_done) begin
               state_in = S_SCL;
            end else begin
               cmd.op = OP_STRIP;
            end
         end
         S_SCL: begin
            cmd.op   = OP_SCL;
            state_in = S_WIDEN;
         end
         S_WIDEN: begin
            if (st.err || st.widen_done) begin
               state_in = S_DONE;
            end else begin
               cmd.op = OP_WIDEN;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/float32_to_scaled_decimal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float32_to_scaled_decimal_unit
// Converts a single-precision pattern to a 96-bit coefficient, scale and sign.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     req_float_bits
//   rsp       out        rsp_valid / rsp_ready     rsp_error, rsp_coeff_*, rsp_scale, rsp_negative
//   csr       in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// NaN, infinity and zero go from load to hand-off; a range reject leaves
// early. Any other item runs through load, normalize, setup, exact rational
// scaling by decades, 24 restoring divide steps, rounding, stripping of up
// to 6 trailing zeros, one multiply by ten per cycle for a negative scale,
// and hand-off.
// Reset is synchronous and clears the sequencer, output valid and config registers.
// A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module float32_to_scaled_decimal_unit import fsdc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_float_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_error,
   output logic [31:0]      rsp_coeff_low,
   output logic [31:0]      rsp_coeff_mid,
   output logic [31:0]      rsp_coeff_high,
   output logic [5:0]       rsp_scale,
   output logic             rsp_negative,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [6:0]  max_log2_ff, min_exp10_ff;
   logic        rsp_valid_ff;
   logic        error_ff, negative_ff;
   logic [31:0] coeff_low_ff, coeff_mid_ff, coeff_high_ff;
   logic [5:0]  scale_ff;
   logic        wr_en, out_free;
   cmd_type     cmd;
   status_type  st;
   logic        dp_error, dp_negative;
   logic [31:0] dp_low, dp_mid, dp_high;
   logic [5:0]  dp_scale;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_log2_ff  <= MAX_LOG2_RESET;
         min_exp10_ff <= MIN_EXP10_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_MAX_LOG2) begin
            max_log2_ff <= pwdata[6:0];
         end else begin
            min_exp10_ff <= pwdata[6:0];
         end
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[1:0] == 2'b00) begin
         unique case (paddr[2])
            REG_MAX_LOG2:  prdata = {25'd0, max_log2_ff};
            REG_MIN_EXP10: prdata = {25'd0, min_exp10_ff};
            default:       prdata = 32'd0;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   fsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .st        (st),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   fsdc_dp u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .float_bits (req_float_bits),
      .max_log2   (max_log2_ff),
      .min_exp10  (min_exp10_ff),
      .st         (st),
      .error      (dp_error),
      .coeff_low  (dp_low),
      .coeff_mid  (dp_mid),
      .coeff_high (dp_high),
      .scale      (dp_scale),
      .negative   (dp_negative)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         error_ff      <= dp_error;
         coeff_low_ff  <= dp_low;
         coeff_mid_ff  <= dp_mid;
         coeff_high_ff <= dp_high;
         scale_ff      <= dp_scale;
         negative_ff   <= dp_negative;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_error      = error_ff;
   assign rsp_coeff_low  = coeff_low_ff;
   assign rsp_coeff_mid  = coeff_mid_ff;
   assign rsp_coeff_high = coeff_high_ff;
   assign rsp_scale      = scale_ff;
   assign rsp_negative   = negative_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while another is in work");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwrote a waiting item");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_coeff_low == 32'd0 && rsp_coeff_mid == 32'd0
         && rsp_coeff_high == 32'd0 && rsp_scale == 6'd0 && !rsp_negative))
      else $error("rejected item carries nonzero fields");

endmodule
`default_nettype wire

FILE: verif/float32_to_scaled_decimal_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_to_scaled_decimal_unit_tb
// Sends single-precision patterns through the converter and compares every
// result, field by field and in order, with a bit-exact integer predictor.
// Several threshold settings are applied, including the range extremes.
// Both handshake sides idle at random, and one long output stall fills the
// block up.
// ----------------------------------------------------------------------------
module float32_to_scaled_decimal_unit_tb import fsdc_pkg::*;;

   typedef logic [383:0] wide_type;

   typedef struct packed {
      logic        error;
      logic [95:0] coeff;
      logic [5:0]  scale;
      logic        negative;
   } decimal_type;

   class decimal_scoreboard;
      decimal_type pending_q[$];
      int unsigned max_log2;
      int          min_exp10;
      int          errors;

      function new();
         max_log2  = 96;
         min_exp10 = -28;
         errors    = 0;
      endfunction

      function automatic wide_type scaled_pow(int unsigned mult, int p2, int p10);
         wide_type a;
         a = wide_type'(mult) << p2;
         repeat (p10) a = a * 10;
         return a;
      endfunction

      function automatic int max0(int x);
         return x > 0 ? x : 0;
      endfunction

      // sign of m*2^e - 2^a*10^b
      function automatic int cmp_pow(int unsigned m, int e, int a, int b);
         wide_type l, r;
         l = scaled_pow(m, max0(e - a), max0(-b));
         r = scaled_pow(1, max0(a - e), max0(b));
         return (l > r) ? 1 : (l < r) ? -1 : 0;
      endfunction

      function automatic decimal_type convert(logic [31:0] bits);
         decimal_type res;
         int unsigned m, q;
         int          e, k, z, sc;
         wide_type    n, d, r;
         logic [99:0] c;
         res = '0;
         if (bits[30:23] == 8'hFF) begin
            res.error = 1'b1;
            return res;
         end
         if (bits[30:23] == 8'h00) begin
            m = 32'(bits[22:0]);
            e = -149;
         end else begin
            m = 32'({1'b1, bits[22:0]});
            e = int'(bits[30:23]) - 150;
         end
         if (m == 0) return res;
         if (cmp_pow(m, e, int'(max_log2), 0) > 0 || cmp_pow(m, e, 0, min_exp10) < 0) begin
            res.error = 1'b1;
            return res;
         end
         k = -46;
         while (k < 40 && cmp_pow(m, e, 0, k + 1) >= 0) k++;
         n = scaled_pow(m, max0(e), max0(6 - k));
         d = scaled_pow(1, max0(-e), max0(k - 6));
         q = 0;
         for (int b = 24; b >= 0; b--)
            if (d * wide_type'(q | (1 << b)) <= n) q = q | (1 << b);
         r = (n - d * wide_type'(q)) << 1;
         if (r > d || (r == d && q[0])) q++;
         if (q >= 10000000) begin
            q = 1000000;
            k++;
         end
         z = 0;
         while (z < 6 && q % 10 == 0) begin
            q = q / 10;
            z++;
         end
         sc = 6 - k - z;
         c  = 100'(q);
         while (sc < 0) begin
            c = c * 10;
            if (c[99:96] != 0) begin
               res = '0;
               res.error = 1'b1;
               return res;
            end
            sc++;
         end
         res.coeff    = c[95:0];
         res.scale    = 6'(sc);
         res.negative = bits[31];
         return res;
      endfunction

      function void note(logic [31:0] bits);
         pending_q.push_back(convert(bits));
      endfunction

      function void check(decimal_type act);
         decimal_type exp_r;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result err=%b coeff=%h scale=%0d neg=%b", $time,
                     act.error, act.coeff, act.scale, act.negative);
            errors++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (act !== exp_r) begin
            $display("%0t: mismatch exp err=%b coeff=%h scale=%0d neg=%b", $time,
                     exp_r.error, exp_r.coeff, exp_r.scale, exp_r.negative);
            $display("%0t:          act err=%b coeff=%h scale=%0d neg=%b", $time,
                     act.error, act.coeff, act.scale, act.negative);
            errors++;
         end
      endfunction
   endclass

   localparam logic [2:0] ADDR_MAX_LOG2  = {REG_MAX_LOG2, 2'b00};
   localparam logic [2:0] ADDR_MIN_EXP10 = {REG_MIN_EXP10, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_float_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_error;
   logic [31:0] rsp_coeff_low;
   logic [31:0] rsp_coeff_mid;
   logic [31:0] rsp_coeff_high;
   logic [5:0]  rsp_scale;
   logic        rsp_negative;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   decimal_scoreboard sb;
   bit quiet;
   bit long_hold;
   int stall_cnt;

   float32_to_scaled_decimal_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_float_bits(req_float_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_error(rsp_error),
      .rsp_coeff_low(rsp_coeff_low), .rsp_coeff_mid(rsp_coeff_mid),
      .rsp_coeff_high(rsp_coeff_high), .rsp_scale(rsp_scale),
      .rsp_negative(rsp_negative),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("float32_to_scaled_decimal_unit_tb: done, errors");
      $finish;
   end

   // output side: random stalls, one long hold on request
   always @(negedge clock) begin
      if (long_hold) begin
         long_hold = 1'b0;
         stall_cnt = 600;
      end
      if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_cnt = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check({rsp_error, rsp_coeff_high, rsp_coeff_mid, rsp_coeff_low,
                   rsp_scale, rsp_negative});
   end

   function automatic logic [31:0] int_to_float(int unsigned v);
      int    p;
      logic [31:0] mant;
      p = 0;
      for (int i = 0; i < 24; i++) if (v[i]) p = i;
      mant = v << (23 - p);
      return {1'b0, 8'(127 + p), mant[22:0]};
   endfunction

   function automatic logic [31:0] random_float();
      logic [31:0] v;
      logic [31:0] f;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1: ;
         2, 3, 4, 5: v[30:23] = 8'($urandom_range(20, 230));
         6, 7: begin
            f = int_to_float($urandom_range(1, 16777215));
            v = {v[31], f[30:0]};
         end
         8: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: v[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(0, 12))
                                                  : 8'($urandom_range(210, 254));
      endcase
      return v;
   endfunction

   // caller sits at a falling edge; valid stays up between back-to-back items
   task automatic send_item(logic [31:0] bits);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_float_bits <= bits;
      do @(posedge clock); while (!req_ready);
      sb.note(bits);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   logic [31:0] directed[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
      32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h6F80_0000, 32'h6F80_0001,
      32'h3F80_0000, 32'hBF00_0000, 32'h4B3C_614E, 32'h4B3C_6141, 32'h4B7F_FFFF,
      32'h4B18_967F, 32'h4CBE_BC20, 32'h3DCC_CCCD, 32'h1277_0000, 32'h11F0_0000,
      32'h4120_0000, 32'h42C8_0000, 32'hFFFF_FFFF
   };
   int unsigned phase_log2[5]  = '{96, 127, 1, 127, 64};
   int          phase_exp10[5] = '{-28, -38, 0, 0, -10};

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_float_bits = '0;
      rsp_ready  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      quiet      = 1'b0;
      long_hold  = 1'b0;
      stall_cnt  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_item(directed[i]);
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         csr_write(ADDR_MAX_LOG2, 32'(phase_log2[ph]));
         csr_write(ADDR_MIN_EXP10, 32'(phase_exp10[ph]) & 32'h7F);
         sb.max_log2  = phase_log2[ph];
         sb.min_exp10 = phase_exp10[ph];
         if (ph == 1) long_hold = 1'b1;
         if (ph == 4) quiet = 1'b1;
         repeat (185) send_item(random_float());
      end
      req_valid <= 1'b0;

      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (sb.errors == 0)
         $display("float32_to_scaled_decimal_unit_tb: done, clean");
      else
         $display("float32_to_scaled_decimal_unit_tb: done, errors");
      $finish;
   end

endmodule
